// File: sv/egql_pkg.sv
// ----------------------------------------------------------------------------
// egql_pkg: shared types and constants of the q-table learner
// sizes of the table, request/result layouts, command and register codes
// ----------------------------------------------------------------------------
package egql_pkg;

	localparam int NUM_CURRENT  = 4;
	localparam int NUM_PREVIOUS = 3;
	localparam int NUM_ACTIONS  = 4;

	localparam int ROWS    = NUM_CURRENT * NUM_PREVIOUS;
	localparam int ENTRIES = ROWS * NUM_ACTIONS;
	localparam int ADDR_W  = $clog2(ENTRIES);
	localparam int ACT_W   = $clog2(NUM_ACTIONS);

	// result timing, counted from the accepting edge
	localparam int GREEDY_DONE_LAT = NUM_ACTIONS + 2;
	localparam int UPD_DONE_LAT    = NUM_ACTIONS + 6;

	typedef logic [ADDR_W-1:0] addr_t;
	typedef logic [ACT_W-1:0]  act_t;

	localparam logic CMD_CHOOSE = 1'b0;
	localparam logic CMD_UPDATE = 1'b1;

	typedef enum logic [1:0] {
		REG_EPSILON_START = 2'd0,
		REG_ALPHA_START   = 2'd1,
		REG_DISCOUNT      = 2'd2
	} cfg_reg_t;

	localparam logic [15:0] EPSILON_RST  = 16'd6554;
	localparam logic [15:0] ALPHA_RST    = 16'd6554;
	localparam logic [15:0] DISCOUNT_RST = 16'd58982;

	// 0.99 in q0.16
	localparam logic [15:0] DECAY_Q16 = 16'd64881;

	localparam logic signed [31:0] Q_MAX = 32'sh7fff_ffff;
	localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_LAST,
		ST_QRD,
		ST_DIFF,
		ST_STEP,
		ST_SUM
	} state_t;

	typedef struct packed {
		logic               command;
		logic [1:0]         current_level;
		logic [1:0]         previous_level;
		logic [1:0]         next_current_level;
		logic [1:0]         next_previous_level;
		logic [1:0]         taken_action;
		logic signed [31:0] reward_value;
		logic [15:0]        random_fraction;
		logic [1:0]         rand_act;
	} req_t;

	typedef struct packed {
		logic [1:0]         chosen_action;
		logic               explored;
		logic signed [31:0] new_q_value;
	} res_t;

	// first table entry of the row, levels clamped to their largest value
	function automatic addr_t row_base(input logic [1:0] cur, input logic [1:0] prev);
		int c;
		int p;
		c = (int'(cur) >= NUM_CURRENT) ? NUM_CURRENT - 1 : int'(cur);
		p = (int'(prev) >= NUM_PREVIOUS) ? NUM_PREVIOUS - 1 : int'(prev);
		return ADDR_W'((c * NUM_PREVIOUS + p) * NUM_ACTIONS);
	endfunction

	function automatic act_t act_clamp(input logic [1:0] a);
		int v;
		v = (int'(a) >= NUM_ACTIONS) ? NUM_ACTIONS - 1 : int'(a);
		return ACT_W'(v);
	endfunction

	function automatic logic [15:0] decay(input logic [15:0] x);
		logic [31:0] p;
		p = 32'(x) * 32'(DECAY_Q16);
		return p[31:16];
	endfunction

endpackage

// File: sv/epsilon_greedy_q_table_learner_top.sv
// ----------------------------------------------------------------------------
// epsilon_greedy_q_table_learner_top: tabular q-learning agent
// epsilon-greedy action choice and saturating q16.16 table updates
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. command 0 chooses
// an action for the state row, command 1 updates Q(row, taken_action) from
// the reward and the best value of the next row. Each request gives one
// result on result, shown for a single cycle with done high; the receiver
// cannot stall, so the result must be taken in that cycle.
// The q table sits in a 48-entry single-port synchronous memory; the row
// scan reads one entry per cycle; the steps of each kind of request are:
//   exploring choose: result the cycle after the request, next request at once
//   greedy choose:    scan of the row, last compare, then the result with done
//   update:           scan of the next row, Q read, difference, step, saturated sum
// busy drops as done rises, so a new request may be given alongside a result.
// Registers are written over cfg_valid/cfg_index/cfg_data (cfg_ready tied high) by the
// user only while the block is idle; it does not enforce this. Reset clears the
// whole table at once via per-entry valid flags and loads register reset values.
module epsilon_greedy_q_table_learner_top (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  egql_pkg::req_t       req,
	output logic                 done,
	output egql_pkg::res_t       result,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [1:0]           cfg_index,
	input  logic [15:0]          cfg_data
);

	egql_pkg::state_t state_q, state_d;
	egql_pkg::act_t   cnt_q;
	egql_pkg::req_t   req_q;
	logic [15:0]      eps_now_q, alpha_now_q, discount_q;

	logic signed [31:0] q_mem [0:egql_pkg::ENTRIES-1];
	logic [egql_pkg::ENTRIES-1:0] ent_vld_q;

	logic               ren, wen;
	egql_pkg::addr_t    raddr, q_addr, scan_base;
	logic signed [31:0] rdata_s1, rdat;
	logic               rvld_s1, scan_vld_s1;
	egql_pkg::act_t     scan_act_s1;

	logic signed [31:0] best_val_q, best_val_c;
	egql_pkg::act_t     best_act_q, best_act_c;

	logic signed [31:0] q_s1;
	logic signed [32:0] gm_s1;
	logic signed [33:0] diff_s2;
	logic signed [34:0] step_s3;
	logic signed [16:0] dsc_sx, alpha_sx;
	logic signed [48:0] gprod;
	logic signed [50:0] sprod;
	logic signed [35:0] res_wide;
	logic signed [31:0] res_sat;

	logic   accept, explore_hit, cfg_wr;
	egql_pkg::res_t result_q;
	logic   done_q;

	assign cfg_ready   = 1'b1;
	assign cfg_wr      = cfg_valid && cfg_ready;
	assign accept      = start && !busy;
	assign explore_hit = (req.command == egql_pkg::CMD_CHOOSE) &&
	                     (req.random_fraction < eps_now_q);

	assign q_addr = egql_pkg::row_base(req_q.current_level, req_q.previous_level) +
	                egql_pkg::ADDR_W'(egql_pkg::act_clamp(req_q.taken_action));
	assign scan_base = (req_q.command == egql_pkg::CMD_UPDATE) ?
	                   egql_pkg::row_base(req_q.next_current_level, req_q.next_previous_level) :
	                   egql_pkg::row_base(req_q.current_level, req_q.previous_level);

	// entries never written read as zero
	assign rdat = rvld_s1 ? rdata_s1 : '0;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			egql_pkg::ST_IDLE: begin
				if (accept && !explore_hit) state_d = egql_pkg::ST_SCAN;
			end
			egql_pkg::ST_SCAN: begin
				if (cnt_q == egql_pkg::ACT_W'(egql_pkg::NUM_ACTIONS - 1))
					state_d = egql_pkg::ST_LAST;
			end
			egql_pkg::ST_LAST: begin
				state_d = (req_q.command == egql_pkg::CMD_UPDATE) ?
				          egql_pkg::ST_QRD : egql_pkg::ST_IDLE;
			end
			egql_pkg::ST_QRD:  state_d = egql_pkg::ST_DIFF;
			egql_pkg::ST_DIFF: state_d = egql_pkg::ST_STEP;
			egql_pkg::ST_STEP: state_d = egql_pkg::ST_SUM;
			egql_pkg::ST_SUM:  state_d = egql_pkg::ST_IDLE;
			default:           state_d = egql_pkg::ST_IDLE;
		endcase
	end

	// state outputs
	always_comb begin
		ren   = 1'b0;
		wen   = 1'b0;
		busy  = 1'b1;
		raddr = scan_base + egql_pkg::ADDR_W'(cnt_q);
		unique case (state_q)
			egql_pkg::ST_IDLE: busy = 1'b0;
			egql_pkg::ST_SCAN: ren = 1'b1;
			egql_pkg::ST_LAST: begin
				ren   = (req_q.command == egql_pkg::CMD_UPDATE);
				raddr = q_addr;
			end
			egql_pkg::ST_SUM:  wen = 1'b1;
			default: begin
			end
		endcase
	end

	// running argmax, strict compare keeps the lowest index on ties
	always_comb begin
		best_val_c = best_val_q;
		best_act_c = best_act_q;
		if (scan_act_s1 == '0 || rdat > best_val_q) begin
			best_val_c = rdat;
			best_act_c = scan_act_s1;
		end
	end

	assign dsc_sx   = {1'b0, discount_q};
	assign alpha_sx = {1'b0, alpha_now_q};
	assign gprod    = 49'(dsc_sx) * 49'(best_val_q);
	assign sprod    = 51'(alpha_sx) * 51'(diff_s2);
	assign res_wide = {{4{q_s1[31]}}, q_s1} + {step_s3[34], step_s3};

	always_comb begin
		if (res_wide[35:31] == 5'b00000 || res_wide[35:31] == 5'b11111)
			res_sat = res_wide[31:0];
		else if (res_wide[35])
			res_sat = egql_pkg::Q_MIN;
		else
			res_sat = egql_pkg::Q_MAX;
	end

	// q table memory
	always_ff @(posedge clk) begin
		if (wen) q_mem[q_addr] <= res_sat;
		if (ren) rdata_s1 <= q_mem[raddr];
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= egql_pkg::ST_IDLE;
			cnt_q       <= '0;
			ent_vld_q   <= '0;
			rvld_s1     <= 1'b0;
			scan_vld_s1 <= 1'b0;
			done_q      <= 1'b0;
			eps_now_q   <= egql_pkg::EPSILON_RST;
			alpha_now_q <= egql_pkg::ALPHA_RST;
			discount_q  <= egql_pkg::DISCOUNT_RST;
		end else begin
			state_q     <= state_d;
			scan_vld_s1 <= (state_q == egql_pkg::ST_SCAN);
			if (ren) rvld_s1 <= ent_vld_q[raddr];
			if (wen) ent_vld_q[q_addr] <= 1'b1;

			if (state_q == egql_pkg::ST_SCAN)
				cnt_q <= cnt_q + egql_pkg::ACT_W'(1);
			else
				cnt_q <= '0;

			done_q <= (accept && explore_hit) ||
			          (state_q == egql_pkg::ST_LAST && req_q.command == egql_pkg::CMD_CHOOSE) ||
			          (state_q == egql_pkg::ST_SUM);

			if (cfg_wr && cfg_index == egql_pkg::REG_EPSILON_START)
				eps_now_q <= cfg_data;
			else if (accept && explore_hit)
				eps_now_q <= egql_pkg::decay(eps_now_q);

			if (cfg_wr && cfg_index == egql_pkg::REG_ALPHA_START)
				alpha_now_q <= cfg_data;
			else if (state_q == egql_pkg::ST_SUM)
				alpha_now_q <= egql_pkg::decay(alpha_now_q);

			if (cfg_wr && cfg_index == egql_pkg::REG_DISCOUNT)
				discount_q <= cfg_data;
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (accept) req_q <= req;
		if (ren) scan_act_s1 <= cnt_q;
		if (scan_vld_s1) begin
			best_val_q <= best_val_c;
			best_act_q <= best_act_c;
		end
		if (state_q == egql_pkg::ST_QRD) begin
			q_s1  <= rdat;
			gm_s1 <= gprod[48:16];
		end
		if (state_q == egql_pkg::ST_DIFF)
			diff_s2 <= {{2{req_q.reward_value[31]}}, req_q.reward_value} +
			           {gm_s1[32], gm_s1} - {{2{q_s1[31]}}, q_s1};
		if (state_q == egql_pkg::ST_STEP)
			step_s3 <= sprod[50:16];

		if (accept && explore_hit) begin
			result_q.chosen_action <= 2'(egql_pkg::act_clamp(req.rand_act));
			result_q.explored      <= 1'b1;
			result_q.new_q_value   <= '0;
		end else if (state_q == egql_pkg::ST_LAST) begin
			result_q.chosen_action <= 2'(best_act_c);
			result_q.explored      <= 1'b0;
			result_q.new_q_value   <= '0;
		end else if (state_q == egql_pkg::ST_SUM) begin
			result_q.chosen_action <= '0;
			result_q.explored      <= 1'b0;
			result_q.new_q_value   <= res_sat;
		end
	end

	assign done   = done_q;
	assign result = result_q;

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result shown while a request is still in progress");

	a_explore_next: assert property (@(posedge clk) disable iff (!arst_n)
		accept && explore_hit |=> done && result.explored)
		else $error("exploring choose did not finish in one cycle");

	a_greedy_lat: assert property (@(posedge clk) disable iff (!arst_n)
		accept && !explore_hit && req.command == egql_pkg::CMD_CHOOSE
		|-> ##(egql_pkg::GREEDY_DONE_LAT) done && !result.explored)
		else $error("greedy choose result missing or late");

	a_update_lat: assert property (@(posedge clk) disable iff (!arst_n)
		accept && req.command == egql_pkg::CMD_UPDATE
		|-> ##(egql_pkg::UPD_DONE_LAT) done)
		else $error("update result missing or late");

	a_result_fields: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (result.new_q_value == '0) ||
		         (!result.explored && result.chosen_action == '0))
		else $error("result mixes choose and update fields");

endmodule
